>>> rtl/core/stepper_move_step_generator_assert.svh
// Assertion macros for the stepper step generator
`ifndef STEPPER_MOVE_STEP_GENERATOR_ASSERT_SVH
`define STEPPER_MOVE_STEP_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define SMSG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stepper step generator check failed");
// next-cycle implication, sampled on clk, off during reset
`define SMSG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stepper step generator check failed");
`else
`define SMSG_ASSERT_NOW(label, ante, cons)
`define SMSG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/core/smsg_pkg.sv
// Shared codes and types for the stepper step generator
package smsg_pkg;

	localparam logic OP_MOVE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_POS_MIN      = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_POS_MAX      = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_INTERVAL = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIR_INVERT   = 2'd3;

	typedef enum logic [1:0] {
		ST_TICK       = 2'd0,
		ST_ACCEPT     = 2'd1,
		ST_REJ_LIMITS = 2'd2,
		ST_REJ_BUSY   = 2'd3
	} status_t;

endpackage

>>> rtl/core/smsg_cfg.sv
// Configuration registers: position limits, minimum interval, direction invert
module smsg_cfg #(
	parameter int POS_BITS = 24,
	parameter int INTERVAL_BITS = 16,
	parameter int CFG_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [smsg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [CFG_BITS-1:0]                  cfg_wr_data,
	output logic signed [POS_BITS-1:0]           pos_min,
	output logic signed [POS_BITS-1:0]           pos_max,
	output logic [INTERVAL_BITS-1:0]             min_interval,
	output logic                                 dir_invert
);

	logic signed [POS_BITS-1:0] pos_min_q;
	logic signed [POS_BITS-1:0] pos_max_q;
	logic [INTERVAL_BITS-1:0]   min_interval_q;
	logic                       dir_invert_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_min_q      <= {1'b1, {(POS_BITS-1){1'b0}}};
			pos_max_q      <= {1'b0, {(POS_BITS-1){1'b1}}};
			min_interval_q <= {{(INTERVAL_BITS-1){1'b0}}, 1'b1};
			dir_invert_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				smsg_pkg::CFG_POS_MIN:      pos_min_q      <= cfg_wr_data[POS_BITS-1:0];
				smsg_pkg::CFG_POS_MAX:      pos_max_q      <= cfg_wr_data[POS_BITS-1:0];
				smsg_pkg::CFG_MIN_INTERVAL: min_interval_q <= cfg_wr_data[INTERVAL_BITS-1:0];
				smsg_pkg::CFG_DIR_INVERT:   dir_invert_q   <= cfg_wr_data[0];
				default: ;
			endcase
		end
	end

	assign pos_min      = pos_min_q;
	assign pos_max      = pos_max_q;
	assign min_interval = min_interval_q;
	assign dir_invert   = dir_invert_q;

endmodule

>>> rtl/core/smsg_core.sv
// Axis state and the per-item move check, countdown and position update
module smsg_core #(
	parameter int POS_BITS = 24,
	parameter int INTERVAL_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  logic                           op,
	input  logic signed [POS_BITS-1:0]     tgt,
	input  logic [INTERVAL_BITS-1:0]       ivl,
	input  logic signed [POS_BITS-1:0]     pos_min,
	input  logic signed [POS_BITS-1:0]     pos_max,
	input  logic [INTERVAL_BITS-1:0]       min_interval,
	input  logic                           dir_invert,
	output logic                           res_pulse,
	output logic                           res_dir,
	output logic signed [POS_BITS-1:0]     res_pos,
	output logic                           res_busy,
	output smsg_pkg::status_t              res_status
);

	`include "stepper_move_step_generator_assert.svh"

	logic signed [POS_BITS-1:0] position_q;
	logic signed [POS_BITS-1:0] target_q;
	logic [INTERVAL_BITS-1:0]   interval_q;
	logic [INTERVAL_BITS-1:0]   countdown_q;
	logic                       moving_q;
	logic                       dir_q;

	logic signed [POS_BITS-1:0] target_d;
	logic [INTERVAL_BITS-1:0]   interval_d;
	logic [INTERVAL_BITS-1:0]   countdown_d;
	logic signed [POS_BITS-1:0] pos_step;
	logic                       in_limits;

	assign in_limits = (tgt >= pos_min) && (tgt <= pos_max) &&
		(ivl != '0) && (ivl >= min_interval);
	// one step toward the target
	assign pos_step = (target_q > position_q) ? position_q + POS_BITS'(1)
		: position_q - POS_BITS'(1);

	always_comb begin
		res_pulse   = 1'b0;
		res_dir     = dir_q;
		res_pos     = position_q;
		res_busy    = moving_q;
		res_status  = smsg_pkg::ST_TICK;
		target_d    = target_q;
		interval_d  = interval_q;
		countdown_d = countdown_q;
		if (op == smsg_pkg::OP_MOVE) begin
			if (moving_q) begin
				res_status = smsg_pkg::ST_REJ_BUSY;
			end else if (!in_limits) begin
				res_status = smsg_pkg::ST_REJ_LIMITS;
			end else begin
				res_status  = smsg_pkg::ST_ACCEPT;
				target_d    = tgt;
				interval_d  = ivl;
				countdown_d = '0;
				if (tgt == position_q) begin
					res_dir  = 1'b1;
					res_busy = 1'b0;
				end else begin
					res_dir  = (tgt > position_q) ^ dir_invert;
					res_busy = 1'b1;
				end
			end
		end else if (moving_q) begin
			if (countdown_q == '0) begin
				res_pulse   = 1'b1;
				res_pos     = pos_step;
				countdown_d = interval_q - INTERVAL_BITS'(1);
				res_busy    = (pos_step != target_q);
			end else begin
				countdown_d = countdown_q - INTERVAL_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= '0;
			target_q    <= '0;
			interval_q  <= '0;
			countdown_q <= '0;
			moving_q    <= 1'b0;
			dir_q       <= 1'b0;
		end else if (fire) begin
			position_q  <= res_pos;
			target_q    <= target_d;
			interval_q  <= interval_d;
			countdown_q <= countdown_d;
			moving_q    <= res_busy;
			dir_q       <= res_dir;
		end
	end

	`SMSG_ASSERT_NOW(a_moving_not_at_target, moving_q, position_q != target_q)
	`SMSG_ASSERT_NEXT(a_accept_clears_countdown, fire && (res_status == smsg_pkg::ST_ACCEPT), countdown_q == '0)
	`SMSG_ASSERT_NEXT(a_pulse_moves_position, fire && res_pulse, position_q != $past(position_q))

endmodule

>>> rtl/core/stepper_move_step_generator.sv
// Stepper step and direction generator: top level with input and result registers.
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle, move or tick, unless out_ready stalls the output;
// limited by the single state update path.
// Reset: asynchronous, clears the axis state to idle at position zero and loads the
// configuration defaults (full position range, minimum interval 1, no invert).
module stepper_move_step_generator #(
	parameter int POS_BITS = 24,
	parameter int INTERVAL_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [smsg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [((POS_BITS > INTERVAL_BITS) ? POS_BITS : INTERVAL_BITS)-1:0] cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic signed [POS_BITS-1:0]           target_position,
	input  logic [INTERVAL_BITS-1:0]             step_interval,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 step_pulse,
	output logic                                 dir_level,
	output logic signed [POS_BITS-1:0]           position,
	output logic                                 busy_res,
	output logic [1:0]                           status
);

	`include "stepper_move_step_generator_assert.svh"

	localparam int CFG_BITS = (POS_BITS > INTERVAL_BITS) ? POS_BITS : INTERVAL_BITS;

	logic signed [POS_BITS-1:0] pos_min;
	logic signed [POS_BITS-1:0] pos_max;
	logic [INTERVAL_BITS-1:0]   min_interval;
	logic                       dir_invert;

	logic                       valid_s1;
	logic                       op_s1;
	logic signed [POS_BITS-1:0] target_s1;
	logic [INTERVAL_BITS-1:0]   interval_s1;

	logic                       valid_s2;
	logic                       pulse_s2;
	logic                       dir_s2;
	logic signed [POS_BITS-1:0] pos_s2;
	logic                       busy_s2;
	smsg_pkg::status_t          status_s2;

	logic                       advance;
	logic                       res_pulse;
	logic                       res_dir;
	logic signed [POS_BITS-1:0] res_pos;
	logic                       res_busy;
	smsg_pkg::status_t          res_status;

	smsg_cfg #(
		.POS_BITS(POS_BITS),
		.INTERVAL_BITS(INTERVAL_BITS),
		.CFG_BITS(CFG_BITS)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.pos_min(pos_min),
		.pos_max(pos_max),
		.min_interval(min_interval),
		.dir_invert(dir_invert)
	);

	// move the item out of the input register when the result register frees up
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1       <= op;
			target_s1   <= target_position;
			interval_s1 <= step_interval;
		end
	end

	smsg_core #(
		.POS_BITS(POS_BITS),
		.INTERVAL_BITS(INTERVAL_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(advance),
		.op(op_s1),
		.tgt(target_s1),
		.ivl(interval_s1),
		.pos_min(pos_min),
		.pos_max(pos_max),
		.min_interval(min_interval),
		.dir_invert(dir_invert),
		.res_pulse(res_pulse),
		.res_dir(res_dir),
		.res_pos(res_pos),
		.res_busy(res_busy),
		.res_status(res_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pulse_s2  <= res_pulse;
			dir_s2    <= res_dir;
			pos_s2    <= res_pos;
			busy_s2   <= res_busy;
			status_s2 <= res_status;
		end
	end

	assign out_valid  = valid_s2;
	assign step_pulse = pulse_s2;
	assign dir_level  = dir_s2;
	assign position   = pos_s2;
	assign busy_res   = busy_s2;
	assign status     = status_s2;

	`SMSG_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, valid_s1)
	`SMSG_ASSERT_NEXT(a_advance_fills_s2, advance, valid_s2)
	`SMSG_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(position))

endmodule
